### hw/rtl/upd_pkg.sv
// Package for the URL percent decoder: types, character constants and hex digit decode.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HI   = 2'd1,
        ESC_LO   = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       end_of_string;
    } upd_result_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.ok  = 1'b1;
            d.val = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            d.ok  = 1'b1;
            d.val = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

### hw/rtl/url_percent_decoder.sv
// Top level of the URL percent decoder: escape tracking, result register and skid stage.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel in_valid/in_stall carries one string byte per beat (in_byte)
//   and a flag on the final byte (last). Output channel out_valid/out_stall
//   carries exactly one result beat per input beat: has_byte, out_byte and
//   end_of_string. '+' and control bytes become a space, "%hh" escapes decode
//   to one byte when both digits are hex and the value is 0x20 or more; the
//   percent and first digit beats produce has_byte = 0 results.
//   An accepted input beat is registered in the result register, or in the skid
//   register when the output stalls. Throughput is one beat per cycle unless the
//   receiver stalls; the decode is a single level of logic into the result register.
//   When the receiver stalls, one more beat is captured in a skid register,
//   then in_stall rises until the output drains.
//   Reset clears the escape state and empties both output registers.
//   Escape state clears after every beat with last set.
//
module url_percent_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       has_byte,
    output logic [7:0] out_byte,
    output logic       end_of_string
);
    import upd_pkg::*;

    esc_phase_t  phase_reg, phase_next;
    logic [3:0]  hi_nib_reg, hi_nib_next;
    logic        hi_ok_reg, hi_ok_next;

    upd_result_t res_next;
    upd_result_t out_reg;
    upd_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    hex_digit_t  dig;
    logic [7:0]  esc_val;
    logic        in_accept;
    logic        out_take;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign dig     = hex_decode(in_byte);
    assign esc_val = {hi_nib_reg, dig.val};

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        hi_nib_next = hi_nib_reg;
        hi_ok_next  = hi_ok_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                ESC_HI:
                begin
                    phase_next  = ESC_LO;
                    hi_nib_next = dig.val;
                    hi_ok_next  = dig.ok;
                end
                ESC_LO:
                begin
                    phase_next  = ESC_IDLE;
                    hi_nib_next = 4'd0;
                    hi_ok_next  = 1'b0;
                end
                default:
                begin
                    phase_next = (in_byte == CH_PERCENT) ? ESC_HI : ESC_IDLE;
                    if (in_byte == CH_PERCENT)
                    begin
                        hi_nib_next = 4'd0;
                        hi_ok_next  = 1'b0;
                    end
                end
            endcase
            if (last)
            begin
                phase_next  = ESC_IDLE;
                hi_nib_next = 4'd0;
                hi_ok_next  = 1'b0;
            end
        end
    end

    // result of the current input beat
    always_comb
    begin
        res_next.has_byte      = 1'b0;
        res_next.out_byte      = 8'd0;
        res_next.end_of_string = last;
        unique case (phase_reg)
            ESC_HI:
            begin
                res_next.has_byte = 1'b0;
            end
            ESC_LO:
            begin
                if (dig.ok && hi_ok_reg && esc_val >= CH_SPACE)
                begin
                    res_next.has_byte = 1'b1;
                    res_next.out_byte = esc_val;
                end
            end
            default:
            begin
                if (in_byte == CH_PLUS || in_byte < CH_SPACE)
                begin
                    res_next.has_byte = 1'b1;
                    res_next.out_byte = CH_SPACE;
                end
                else if (in_byte != CH_PERCENT)
                begin
                    res_next.has_byte = 1'b1;
                    res_next.out_byte = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ESC_IDLE;
            hi_nib_reg <= 4'd0;
            hi_ok_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hi_nib_reg <= hi_nib_next;
            hi_ok_reg  <= hi_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_accept)
                out_reg <= res_next;
        end
        else if (in_accept)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign has_byte      = out_reg.has_byte;
    assign out_byte      = out_reg.out_byte;
    assign end_of_string = out_reg.end_of_string;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held while output register empty");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.has_byte) |-> (out_reg.out_byte == 8'd0))
        else $error("empty result carries a nonzero byte");

    a_no_ctrl_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.has_byte) |-> (out_reg.out_byte >= CH_SPACE))
        else $error("control byte emitted");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last) |=> (phase_reg == ESC_IDLE && !hi_ok_reg))
        else $error("escape state survived end of string");

endmodule

### verif/url_percent_decoder_tb.sv
// Testbench for url_percent_decoder: directed and random strings, a self-checking decode model.
`timescale 1ns / 1ps

module url_percent_decoder_tb;

    import upd_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int RAND_BEATS = 1000;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 20;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         drain_first;
    } text_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_of_string;

    text_beat_t  text_q[$];
    upd_result_t decoded_q[$];

    esc_phase_t  esc_phase = ESC_IDLE;
    logic [3:0]  hi_nibble = 4'd0;
    logic        hi_ok = 1'b0;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int err_count = 0;

    url_percent_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .has_byte      (has_byte),
        .out_byte      (out_byte),
        .end_of_string (end_of_string)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic upd_result_t decode_beat(input logic [7:0] c, input logic fin);
        upd_result_t r;
        logic [3:0]  lo;
        logic        lo_ok;
        logic [7:0]  val;
        r.has_byte      = 1'b0;
        r.out_byte      = 8'h00;
        r.end_of_string = fin;
        case (esc_phase)
            ESC_HI:
            begin
                hi_ok     = hex_digit(c, hi_nibble);
                esc_phase = ESC_LO;
            end
            ESC_LO:
            begin
                lo_ok     = hex_digit(c, lo);
                val       = {hi_nibble, lo};
                esc_phase = ESC_IDLE;
                if (lo_ok && hi_ok && val >= CH_SPACE)
                begin
                    r.has_byte = 1'b1;
                    r.out_byte = val;
                end
                hi_nibble = 4'd0;
                hi_ok     = 1'b0;
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                if (c == CH_PLUS || c < CH_SPACE)
                begin
                    r.has_byte = 1'b1;
                    r.out_byte = CH_SPACE;
                end
                else if (c == CH_PERCENT)
                begin
                    esc_phase = ESC_HI;
                    hi_nibble = 4'd0;
                    hi_ok     = 1'b0;
                end
                else
                begin
                    r.has_byte = 1'b1;
                    r.out_byte = c;
                end
            end
        endcase
        if (fin)
        begin
            esc_phase = ESC_IDLE;
            hi_nibble = 4'd0;
            hi_ok     = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    task automatic add_beat(input logic [7:0] c, input logic fin, input bit drain_first = 1'b0);
        text_beat_t t;
        t.ch          = c;
        t.fin         = fin;
        t.drain_first = drain_first;
        text_q.push_back(t);
    endtask

    task automatic add_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            add_beat(s[i], fin && (i == s.len() - 1));
    endtask

    // well-formed escapes, some junk escapes, plus, control and random bytes; some cut short at the end
    task automatic add_random_string(input bit drain_first);
        logic [7:0] s[$];
        logic [7:0] v;
        int len;
        int pick;
        len = $urandom_range(1, 12);
        while (s.size() < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                v = 8'($urandom);
                if (pick < 5)
                    v = v & 8'h1F;
                s.push_back(CH_PERCENT);
                s.push_back(hex_char(v[7:4]));
                s.push_back(hex_char(v[3:0]));
            end
            else if (pick < 42)
            begin
                s.push_back(CH_PERCENT);
                s.push_back(8'($urandom));
                s.push_back(8'($urandom));
            end
            else if (pick < 55)
                s.push_back(CH_PLUS);
            else if (pick < 65)
                s.push_back(8'($urandom_range(0, 31)));
            else
                s.push_back(8'($urandom));
        end
        if ($urandom_range(0, 7) == 0 && s.size() > 1)
            s.pop_back();
        for (int i = 0; i < s.size(); i++)
            add_beat(s[i], i == s.size() - 1, drain_first && i == 0);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // beat held until taken
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (text_q.size() != 0 &&
                     !(text_q[0].drain_first && decoded_q.size() != 0))
            begin
                text_beat_t t;
                t = text_q.pop_front();
                in_valid <= 1'b1;
                in_byte  <= t.ch;
                last     <= t.fin;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = ~tx_burst;
                send_gap = tx_burst ? 0 : $urandom_range(0, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_burst = ~rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        upd_result_t want;
        if (rst_n)
        begin
            in_taken  = in_valid && !in_stall;
            out_taken = out_valid && !out_stall;
            if (out_taken)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected beat: has_byte %0b out_byte %02h end_of_string %0b",
                           has_byte, out_byte, end_of_string);
                    err_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (has_byte !== want.has_byte)
                    begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, has_byte);
                        err_count++;
                    end
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
                        err_count++;
                    end
                    if (end_of_string !== want.end_of_string)
                    begin
                        $error("end_of_string: expected %0b, got %0b",
                               want.end_of_string, end_of_string);
                        err_count++;
                    end
                end
            end
            if (in_taken)
                decoded_q.push_back(decode_beat(in_byte, last));
            idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int start_size;
        // control bytes, plus, high bytes
        add_beat(8'h00, 1'b0);
        add_beat(8'h1F, 1'b0);
        add_beat(CH_PLUS, 1'b0);
        add_beat(8'h80, 1'b0);
        add_beat(8'hFF, 1'b0);
        // mixed-case hex, value below space, bad first digit with plus consumed
        add_text("%fF", 1'b0);
        add_text("%1f", 1'b0);
        add_text("%G+", 1'b0);
        // bad second digit that is a control byte
        add_text("%4", 1'b0);
        add_beat(8'h00, 1'b0);
        // escape completes on the last beat, strings ending inside an escape
        add_text("%20", 1'b1);
        add_text("%a", 1'b1);
        add_text("%", 1'b1);
        add_text("x", 1'b1);
        start_size = text_q.size();
        add_random_string(1'b1);
        while (text_q.size() - start_size < RAND_BEATS)
            add_random_string($urandom_range(0, 29) == 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
